@@ hdl/pfb_pkg.sv @@
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared constants, codes and types of the page framebuffer blit and flush
// block.
// ----------------------------------------------------------------------------
package pfb_pkg;

	localparam int PANEL_WIDTH  = 128;
	localparam int PANEL_HEIGHT = 64;
	localparam int PACKET_BYTES = 32;

	localparam int PAGES       = (PANEL_HEIGHT + 7) / 8;
	localparam int FRAME_BYTES = PANEL_WIDTH * PAGES;
	localparam int ADDR_W      = $clog2(FRAME_BYTES);
	localparam int PKT_W       = $clog2(PACKET_BYTES);
	localparam int POS_W       = 10;
	localparam int CFG_IDX_W   = 3;

	localparam logic [7:0] CONTROL_BYTE       = 8'h40;
	localparam logic [7:0] MSB_PIXEL          = 8'h80;
	localparam logic [7:0] ORIGIN_X_RESET     = 8'd0;
	localparam logic [7:0] ORIGIN_Y_RESET     = 8'd0;
	localparam logic [7:0] IMAGE_WIDTH_RESET  = 8'd128;
	localparam logic [7:0] IMAGE_HEIGHT_RESET = 8'd64;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_BLIT  = 2'd1,
		OP_FLUSH = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X     = 3'd0,
		REG_ORIGIN_Y     = 3'd1,
		REG_IMAGE_WIDTH  = 3'd2,
		REG_IMAGE_HEIGHT = 3'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_BLIT,
		CMD_FLUSH
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [7:0]        mask;
		logic [POS_W-1:0]  px0;
		logic [ADDR_W-1:0] page_base;
		logic [7:0]        bit_sel;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_control;
		logic       last_of_packet;
		logic       last_of_frame;
	} res_t;

endpackage

@@ hdl/pfb_if.sv @@
// ----------------------------------------------------------------------------
// pfb_if
// Valid/ready channels of the block: input items, configuration writes and
// packet bytes.
// ----------------------------------------------------------------------------
interface pfb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] bitmap_byte;

	modport source(output valid, operation, bitmap_byte, input ready);
	modport sink(input valid, operation, bitmap_byte, output ready);
endinterface

interface pfb_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [pfb_pkg::CFG_IDX_W-1:0]  index;
	logic [7:0]                     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

interface pfb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_control;
	logic       last_of_packet;
	logic       last_of_frame;

	modport source(output valid, out_byte, is_control, last_of_packet, last_of_frame,
		input ready);
	modport sink(input valid, out_byte, is_control, last_of_packet, last_of_frame,
		output ready);
endinterface

@@ hdl/pfb_ram.sv @@
// ----------------------------------------------------------------------------
// pfb_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module pfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ hdl/pfb_front.sv @@
// ----------------------------------------------------------------------------
// pfb_front
// Accepts items and configuration writes, tracks the bitmap cursor and turns
// each item of a known operation into a framebuffer command.
// ----------------------------------------------------------------------------
module pfb_front (
	input  logic          clk,
	input  logic          arst_n,
	pfb_in_if.sink        items,
	pfb_cfg_if.sink       cfg,
	input  logic          init_busy,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output pfb_pkg::cmd_t cmd
);
	import pfb_pkg::*;

	logic [7:0]       origin_x_q;
	logic [7:0]       origin_y_q;
	logic [7:0]       image_width_q;
	logic [7:0]       image_height_q;
	logic [7:0]       row_q;
	logic [4:0]       bcol_q;

	logic [8:0]       width_pad;
	logic [5:0]       row_bytes;
	logic [5:0]       bcol_inc;
	logic [8:0]       row_inc;
	logic             row_wrap;
	logic             row_in;
	logic             row_ok;
	logic [POS_W-1:0] px0;
	logic [POS_W-1:0] py;
	logic [7:0]       mask;
	logic             op_known;
	cmd_op_t          cmd_op;
	logic             accept;
	logic             cfg_write;

	assign width_pad = {1'b0, image_width_q} + 9'd7;
	assign row_bytes = (width_pad[8:3] == 6'd0) ? 6'd1 : width_pad[8:3];
	assign bcol_inc  = {1'b0, bcol_q} + 6'd1;
	assign row_inc   = {1'b0, row_q} + 9'd1;
	assign row_wrap  = row_inc >= {1'b0, image_height_q};
	assign row_in    = row_q < image_height_q;

	assign px0 = {{2{origin_x_q[7]}}, origin_x_q} + {2'b00, bcol_q, 3'b000};
	assign py  = {{2{origin_y_q[7]}}, origin_y_q} + {2'b00, row_q};
	assign row_ok = !py[POS_W-1] && (py < POS_W'(PANEL_HEIGHT));

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			mask[b] = (|(items.bitmap_byte & (MSB_PIXEL >> b))) &&
				({bcol_q, 3'(b)} < image_width_q) && row_in && row_ok;
		end
	end

	always_comb begin
		op_known = 1'b1;
		cmd_op   = CMD_CLEAR;
		case (items.operation)
			OP_CLEAR: cmd_op = CMD_CLEAR;
			OP_BLIT:  cmd_op = CMD_BLIT;
			OP_FLUSH: cmd_op = CMD_FLUSH;
			default:  op_known = 1'b0;
		endcase
	end

	assign cmd.op        = cmd_op;
	assign cmd.mask      = mask;
	assign cmd.px0       = px0;
	assign cmd.page_base = ADDR_W'(int'(py[POS_W-1:3]) * PANEL_WIDTH);
	assign cmd.bit_sel   = 8'd1 << py[2:0];

	assign items.ready = cmd_ready && !init_busy;
	assign cmd_valid   = items.valid && !init_busy && op_known;
	assign accept      = items.valid && items.ready;
	assign cfg.ready   = 1'b1;
	assign cfg_write   = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= ORIGIN_X_RESET;
			origin_y_q     <= ORIGIN_Y_RESET;
			image_width_q  <= IMAGE_WIDTH_RESET;
			image_height_q <= IMAGE_HEIGHT_RESET;
			row_q          <= '0;
			bcol_q         <= '0;
		end else if (cfg_write) begin
			case (cfg.index)
				REG_ORIGIN_X: begin
					origin_x_q <= cfg.data;
					row_q      <= '0;
					bcol_q     <= '0;
				end
				REG_ORIGIN_Y: begin
					origin_y_q <= cfg.data;
					row_q      <= '0;
					bcol_q     <= '0;
				end
				REG_IMAGE_WIDTH: begin
					image_width_q <= cfg.data;
					row_q         <= '0;
					bcol_q        <= '0;
				end
				REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg.data;
					row_q          <= '0;
					bcol_q         <= '0;
				end
				default: ;
			endcase
		end else if (accept) begin
			case (items.operation)
				OP_CLEAR: begin
					row_q  <= '0;
					bcol_q <= '0;
				end
				OP_BLIT: begin
					if (bcol_inc >= row_bytes) begin
						bcol_q <= '0;
						row_q  <= row_wrap ? 8'd0 : row_inc[7:0];
					end else begin
						bcol_q <= bcol_inc[4:0];
					end
				end
				default: ;
			endcase
		end
	end
endmodule

@@ hdl/pfb_cmdq.sv @@
// ----------------------------------------------------------------------------
// pfb_cmdq
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module pfb_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  pfb_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output pfb_pkg::cmd_t pop_cmd
);
	import pfb_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_cmd    = slot_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end
endmodule

@@ hdl/pfb_back.sv @@
// ----------------------------------------------------------------------------
// pfb_back
// Executes commands on the frame store: clearing sweep, read-modify-write
// blit of one bitmap byte, and packet streaming through a two-entry output
// queue.
// ----------------------------------------------------------------------------
module pfb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  pfb_pkg::cmd_t cmd,
	output logic          init_busy,
	pfb_out_if.source     results
);
	import pfb_pkg::*;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_BLIT,
		ST_FCTL,
		ST_FDAT
	} state_t;

	state_t            state_q;
	logic              init_q;
	logic [ADDR_W-1:0] sweep_addr_q;
	cmd_t              cur_q;
	logic [3:0]        k_q;
	logic              wr_en_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [PKT_W-1:0]  left_q;
	logic              endf_q;
	logic              pend_q;
	logic              pend_last_q;

	res_t              res_q [2];
	logic              res_wr_q;
	logic              res_rd_q;
	logic [1:0]        cnt_q;

	logic [ADDR_W:0]   remain;
	logic [POS_W-1:0]  x_k;
	logic              col_ok;
	logic [ADDR_W-1:0] blit_addr;
	logic              blit_rd;
	logic              fl_rd;
	logic              ctl_push;
	logic              push;
	logic              pop_out;
	logic [2:0]        occ;
	res_t              push_res;
	logic              sweep_we;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	assign cmd_ready = state_q == ST_IDLE;
	assign init_busy = init_q;

	assign remain = (ADDR_W+1)'(FRAME_BYTES) - {1'b0, ptr_q};

	assign x_k       = cur_q.px0 + POS_W'(k_q[2:0]);
	assign col_ok    = cur_q.mask[k_q[2:0]] && !x_k[POS_W-1] &&
		(x_k < POS_W'(PANEL_WIDTH));
	assign blit_addr = cur_q.page_base + ADDR_W'(x_k);
	assign blit_rd   = (state_q == ST_BLIT) && !k_q[3];

	assign pop_out  = results.valid && results.ready;
	assign occ      = {1'b0, cnt_q} + {2'b00, pend_q} - {2'b00, pop_out};
	assign fl_rd    = (state_q == ST_FDAT) && (occ <= 3'd1);
	assign ctl_push = (state_q == ST_FCTL) && !pend_q && ((cnt_q != 2'd2) || pop_out);
	assign push     = pend_q || ctl_push;

	always_comb begin
		if (pend_q) begin
			push_res.out_byte       = ram_rdata;
			push_res.is_control     = 1'b0;
			push_res.last_of_packet = pend_last_q;
			push_res.last_of_frame  = endf_q;
		end else begin
			push_res.out_byte       = CONTROL_BYTE;
			push_res.is_control     = 1'b1;
			push_res.last_of_packet = 1'b0;
			push_res.last_of_frame  = endf_q;
		end
	end

	assign sweep_we  = state_q == ST_SWEEP;
	assign ram_we    = sweep_we || wr_en_q;
	assign ram_waddr = sweep_we ? sweep_addr_q : wr_addr_q;
	assign ram_wdata = sweep_we ? 8'd0 : (ram_rdata | cur_q.bit_sel);
	assign ram_re    = blit_rd || fl_rd;
	assign ram_raddr = blit_rd ? blit_addr : ptr_q;

	pfb_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_BYTES)
	) u_frame_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			init_q       <= 1'b1;
			sweep_addr_q <= '0;
			k_q          <= '0;
			wr_en_q      <= 1'b0;
			wr_addr_q    <= '0;
			ptr_q        <= '0;
			left_q       <= '0;
			endf_q       <= 1'b0;
			pend_q       <= 1'b0;
			pend_last_q  <= 1'b0;
		end else begin
			pend_q      <= fl_rd;
			pend_last_q <= left_q == PKT_W'(1);
			wr_en_q     <= 1'b0;
			case (state_q)
				ST_SWEEP: begin
					if (sweep_addr_q == ADDR_W'(FRAME_BYTES - 1)) begin
						sweep_addr_q <= '0;
						init_q       <= 1'b0;
						state_q      <= ST_IDLE;
					end else begin
						sweep_addr_q <= sweep_addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							CMD_CLEAR: state_q <= ST_SWEEP;
							CMD_BLIT: begin
								k_q     <= '0;
								state_q <= ST_BLIT;
							end
							CMD_FLUSH: begin
								if (int'(remain) <= PACKET_BYTES - 1) begin
									left_q <= PKT_W'(remain);
									endf_q <= 1'b1;
								end else begin
									left_q <= PKT_W'(PACKET_BYTES - 1);
									endf_q <= 1'b0;
								end
								state_q <= ST_FCTL;
							end
							default: ;
						endcase
					end
				end
				ST_BLIT: begin
					wr_en_q   <= col_ok && !k_q[3];
					wr_addr_q <= blit_addr;
					if (k_q[3]) begin
						k_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				ST_FCTL: begin
					if (ctl_push) begin
						state_q <= ST_FDAT;
					end
				end
				ST_FDAT: begin
					if (fl_rd) begin
						ptr_q  <= (ptr_q == ADDR_W'(FRAME_BYTES - 1)) ? '0 : ptr_q + 1'b1;
						left_q <= left_q - 1'b1;
						if (left_q == PKT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cur_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q <= 1'b0;
			res_rd_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				res_wr_q <= !res_wr_q;
			end
			if (pop_out) begin
				res_rd_q <= !res_rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_out};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q[res_wr_q] <= push_res;
		end
	end

	assign results.valid          = cnt_q != 2'd0;
	assign results.out_byte       = res_q[res_rd_q].out_byte;
	assign results.is_control     = res_q[res_rd_q].is_control;
	assign results.last_of_packet = res_q[res_rd_q].last_of_packet;
	assign results.last_of_frame  = res_q[res_rd_q].last_of_frame;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && (cnt_q == 2'd2)) |-> pop_out)
		else $error("output queue overflow");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(sweep_we && wr_en_q))
		else $error("sweep and blit write collide");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= ADDR_W'(FRAME_BYTES - 1))
		else $error("flush pointer out of range");

	a_ctl_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.is_control) |->
		(results.out_byte == CONTROL_BYTE) && !results.last_of_packet)
		else $error("bad control byte");

	a_pend_no_ctl: assert property (@(posedge clk) disable iff (!arst_n)
		$past(fl_rd) |-> !ctl_push)
		else $error("control byte collides with read data");
endmodule

@@ hdl/page_framebuffer_blit_and_flush.sv @@
// ----------------------------------------------------------------------------
// page_framebuffer_blit_and_flush
// Holds a 128x64 one-bit framebuffer in page order (one byte per column per
// 8-row page). Operation 0 clears it, operation 1 ORs one bitmap byte in at
// the configured origin with clipping, operation 2 sends the next bus packet:
// control byte 0x40 then up to 31 framebuffer bytes, last_of_frame marking
// the packet that ends the frame. After reset the frame store is swept to
// zero, during which no item is taken; configuration writes are always
// taken. A clear sweeps the store to zero again, and a bitmap byte takes
// eight read-modify-writes through the store's one read and one write
// port. Items queue two deep ahead of the store, and the output holds two
// packet bytes.
// ----------------------------------------------------------------------------
module page_framebuffer_blit_and_flush (
	input  logic      clk,
	input  logic      arst_n,
	pfb_in_if.sink    items,
	pfb_cfg_if.sink   cfg,
	pfb_out_if.source results
);
	import pfb_pkg::*;

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;
	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;
	logic init_busy;

	pfb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.cfg      (cfg),
		.init_busy(init_busy),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd)
	);

	pfb_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(cmd_valid),
		.push_ready(cmd_ready),
		.push_cmd  (cmd),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_cmd   (q_cmd)
	);

	pfb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(q_valid),
		.cmd_ready(q_ready),
		.cmd      (q_cmd),
		.init_busy(init_busy),
		.results  (results)
	);
endmodule
